/* rtl/ccdg_pkg.sv */
`default_nettype none

package ccdg_pkg;

    // Line store geometry: eight row slots of 1024 pixels
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned ADDR_W  = SLOT_W + COL_W;
    localparam int unsigned DEPTH   = 2 ** ADDR_W;
    localparam int unsigned MAX_RAD = 4;
    localparam int unsigned MAX_DIM = 1024;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;
    localparam int unsigned CFG_DATA_W = 11;

    // Pixel word: blue in [7:0], green in [15:8], red in [23:16]
    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] grad_blue;
        logic [7:0] grad_green;
        logic [7:0] grad_red;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        logic accept;    // input transfer; issue top and left reads
        logic rd_right;  // read right neighbour, write current pixel
        logic diff;      // form horizontal difference and saturated sum
        logic load_out;  // divide and load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;      // latched pixel is interior and gives a result
    } ctrl_sts_t;

    // Per channel clamped difference, larger channel sum minus smaller;
    // a wins ties.
    function automatic pixel_t sum_ordered_diff(input pixel_t a, input pixel_t b);
        logic [9:0] sa;
        logic [9:0] sb;
        pixel_t     hi;
        pixel_t     lo;
        pixel_t     res;
        logic [7:0] h;
        logic [7:0] l;
        sa = 10'(a[7:0]) + 10'(a[15:8]) + 10'(a[23:16]);
        sb = 10'(b[7:0]) + 10'(b[15:8]) + 10'(b[23:16]);
        if (sb > sa)
        begin
            hi = b;
            lo = a;
        end
        else
        begin
            hi = a;
            lo = b;
        end
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            h = hi[8*k +: 8];
            l = lo[8*k +: 8];
            res[8*k +: 8] = (h > l) ? 8'(h - l) : 8'd0;
        end
        return res;
    endfunction

    // s / r for r in 1..4, round to nearest, ties to even
    function automatic logic [7:0] div_round_even(input logic [7:0] s, input logic [2:0] r);
        logic [16:0] prod;
        logic [7:0]  q;
        logic [7:0]  rem;
        logic        up;
        prod = '0;
        rem  = '0;
        q    = s;
        up   = 1'b0;
        case (r)
            3'd2:
            begin
                q  = {1'b0, s[7:1]};
                up = s[0] & s[1];
            end
            3'd3:
            begin
                // 171/512 reciprocal is exact for 8-bit dividends
                prod = 17'(s) * 17'd171;
                q    = prod[16:9];
                rem  = 8'(s - 8'(q * 8'd3));
                up   = (rem[1:0] == 2'd2);
            end
            3'd4:
            begin
                q  = {2'b00, s[7:2]};
                up = s[1] & (s[0] | s[2]);
            end
            default:
            begin
                q  = s;
                up = 1'b0;
            end
        endcase
        return 8'(q + 8'(up));
    endfunction

endpackage

`default_nettype wire

/* rtl/color_central_difference_gradient.sv */
// Colour central-difference gradient over a raster stream of 8-bit BGR pixels.
// Input channel: in_valid / in_stall / in_data carry one pixel per transfer, in
// raster order. Output channel: out_valid / out_stall / out_data carry the
// gradient of one interior pixel per transfer; border pixels give nothing.
// The result for centre row y-R is sent on the transfer of pixel (y, x).
// The block takes one pixel at a time. An interior pixel goes through transfer,
// right-neighbour read and line store write, difference and divide; a border
// pixel through the first two. Of the two line store read ports, one reads the
// row above and the other the left and then the right neighbour. The result is
// held in turn in left_reg and dy_reg, sum_reg and the output register.
// When the receiver stalls, the output register holds; the next pixel is still
// taken, and the block waits in its divide step only if a second result is ready
// before the first has gone. Configuration (radius, frame_width, frame_height)
// is written through cfg_we / cfg_index / cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Reset clears
// the raster counters and the handshake state and restores the default
// configuration (R = 1, 640 x 480); the line store is not cleared.
`default_nettype none

module color_central_difference_gradient (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire ccdg_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output ccdg_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [ccdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Command and status between sequencer and datapath
    ccdg_pkg::ctrl_cmd_t cmd;
    ccdg_pkg::ctrl_sts_t sts;

    ccdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Counters, line store, difference and divide units, output register
    ccdg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

/* rtl/ccdg_line_store.sv */
`default_nettype none

// Eight rows of pixels; one write port, two registered read ports.
module ccdg_line_store (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ccdg_pkg::ADDR_W-1:0] waddr,
    input  wire ccdg_pkg::pixel_t            wdata,
    input  wire logic                        re_a,
    input  wire logic [ccdg_pkg::ADDR_W-1:0] raddr_a,
    output ccdg_pkg::pixel_t                 rdata_a,
    input  wire logic                        re_b,
    input  wire logic [ccdg_pkg::ADDR_W-1:0] raddr_b,
    output ccdg_pkg::pixel_t                 rdata_b
);

    ccdg_pkg::pixel_t mem [ccdg_pkg::DEPTH];
    ccdg_pkg::pixel_t rd_a_reg;
    ccdg_pkg::pixel_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rd_a_reg <= mem[raddr_a];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

/* rtl/ccdg_datapath.sv */
`default_nettype none

module ccdg_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ccdg_pkg::ctrl_cmd_t              cmd,
    output ccdg_pkg::ctrl_sts_t                   sts,
    input  wire ccdg_pkg::in_item_t               in_data,
    output ccdg_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [ccdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned CW = ccdg_pkg::COL_W;
    localparam int unsigned SW = ccdg_pkg::SLOT_W;
    localparam int unsigned AW = ccdg_pkg::ADDR_W;
    localparam int unsigned DW = ccdg_pkg::CFG_DATA_W;

    // Configuration
    logic [2:0]    radius_reg;
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;

    // Raster position of the next pixel
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic [CW-1:0] x_next;
    logic [CW-1:0] y_next;

    // Per-item registers
    ccdg_pkg::pixel_t   pix_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [AW-1:0]      right_addr_reg;
    logic               emit_reg;
    logic               last_reg;
    ccdg_pkg::pixel_t   left_reg;
    ccdg_pkg::pixel_t   dy_reg;
    ccdg_pkg::pixel_t   sum_reg;
    ccdg_pkg::out_item_t out_reg;

    logic [2:0]    r_eff;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] two_r;
    logic [DW-1:0] x_plus_r;
    logic          emit_now;
    logic          last_now;
    logic [SW-1:0] top_slot;
    logic [SW-1:0] ctr_slot;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] left_addr;
    logic [AW-1:0] right_addr;
    logic [AW-1:0] rd_b_addr;
    ccdg_pkg::pixel_t cur_pix;
    ccdg_pkg::pixel_t rd_a;
    ccdg_pkg::pixel_t rd_b;
    ccdg_pkg::pixel_t dx;
    ccdg_pkg::pixel_t sum_next;
    logic [8:0]       ch_sum;

    // Effective limits
    always_comb
    begin
        if (radius_reg == 3'd0)
            r_eff = 3'd1;
        else if (radius_reg > 3'(ccdg_pkg::MAX_RAD))
            r_eff = 3'(ccdg_pkg::MAX_RAD);
        else
            r_eff = radius_reg;

        if (width_reg == '0)
            w_eff = DW'(1);
        else if (width_reg > DW'(ccdg_pkg::MAX_DIM))
            w_eff = DW'(ccdg_pkg::MAX_DIM);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DW'(1);
        else if (height_reg > DW'(ccdg_pkg::MAX_DIM))
            h_eff = DW'(ccdg_pkg::MAX_DIM);
        else
            h_eff = height_reg;
    end

    assign two_r    = DW'({r_eff, 1'b0});
    assign x_plus_r = DW'(x_reg) + DW'(r_eff);

    assign emit_now = (DW'(y_reg) >= two_r) && (DW'(y_reg) < h_eff) && (w_eff > two_r) &&
                      (x_reg >= CW'(r_eff)) && (x_plus_r < w_eff);
    assign last_now = (DW'(y_reg) == DW'(h_eff - DW'(1))) &&
                      (DW'(x_plus_r + DW'(1)) == w_eff);

    // Row slot is row mod 8
    assign top_slot   = SW'(y_reg[SW-1:0] - SW'(two_r));
    assign ctr_slot   = SW'(y_reg[SW-1:0] - r_eff);
    assign top_addr   = {top_slot, x_reg};
    assign left_addr  = {ctr_slot, CW'(x_reg - CW'(r_eff))};
    assign right_addr = {ctr_slot, CW'(x_reg + CW'(r_eff))};
    assign rd_b_addr  = cmd.accept ? left_addr : right_addr_reg;

    assign cur_pix = {in_data.red, in_data.green, in_data.blue};

    always_comb
    begin
        if (DW'(x_reg) + DW'(1) >= w_eff)
        begin
            x_next = '0;
            y_next = (DW'(y_reg) + DW'(1) >= h_eff) ? '0 : CW'(y_reg + CW'(1));
        end
        else
        begin
            x_next = CW'(x_reg + CW'(1));
            y_next = y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd1;
            width_reg  <= DW'(640);
            height_reg <= DW'(480);
            x_reg      <= '0;
            y_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ccdg_pkg::CFG_RADIUS:       radius_reg <= cfg_data[2:0];
                    ccdg_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    ccdg_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (cmd.accept)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
        end
    end

    ccdg_line_store u_store (
        .clk     (clk),
        .we      (cmd.rd_right),
        .waddr   (wr_addr_reg),
        .wdata   (pix_reg),
        .re_a    (cmd.accept),
        .raddr_a (top_addr),
        .rdata_a (rd_a),
        .re_b    (cmd.accept | cmd.rd_right),
        .raddr_b (rd_b_addr),
        .rdata_b (rd_b)
    );

    assign dx = ccdg_pkg::sum_ordered_diff(left_reg, rd_b);

    always_comb
    begin
        sum_next = '0;
        ch_sum   = '0;
        for (int k = 0; k < 3; k++)
        begin
            ch_sum = 9'(dx[8*k +: 8]) + 9'(dy_reg[8*k +: 8]);
            sum_next[8*k +: 8] = ch_sum[8] ? 8'hFF : ch_sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            emit_reg <= emit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg        <= cur_pix;
            wr_addr_reg    <= {y_reg[SW-1:0], x_reg};
            right_addr_reg <= right_addr;
            last_reg       <= last_now;
        end
        if (cmd.rd_right)
        begin
            left_reg <= rd_b;
            dy_reg   <= ccdg_pkg::sum_ordered_diff(rd_a, pix_reg);
        end
        if (cmd.diff)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.load_out)
        begin
            out_reg.grad_blue  <= ccdg_pkg::div_round_even(sum_reg[7:0], r_eff);
            out_reg.grad_green <= ccdg_pkg::div_round_even(sum_reg[15:8], r_eff);
            out_reg.grad_red   <= ccdg_pkg::div_round_even(sum_reg[23:16], r_eff);
            out_reg.frame_last <= last_reg;
        end
    end

    assign sts.emit = emit_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

/* rtl/ccdg_ctrl.sv */
`default_nettype none

module ccdg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ccdg_pkg::ctrl_cmd_t      cmd,
    input  wire ccdg_pkg::ctrl_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RIGHT,
        S_DIFF,
        S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.rd_right = (state_reg == S_RIGHT);
        cmd.diff     = (state_reg == S_DIFF);
        cmd.load_out = (state_reg == S_DIV) && out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = in_valid ? S_RIGHT : S_IDLE;
            S_RIGHT: state_next = sts.emit ? S_DIFF : S_IDLE;
            S_DIFF:  state_next = S_DIV;
            S_DIV:   state_next = out_free ? S_IDLE : S_DIV;
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* tb/color_central_difference_gradient_tb.sv */
module color_central_difference_gradient_tb;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;       // margin for the last pixel to leave the block
    localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int unsigned RANDOM_PIXELS = 400;
    localparam int unsigned SLOTS         = 2 * ccdg_pkg::MAX_RAD;
    // Widest frame the random stream uses; the fill frame writes every row
    // slot up to this column.
    localparam int unsigned FILL_WIDTH    = 2 * ccdg_pkg::MAX_RAD + 16;

    // 5 x 5 frame at radius 1: black, white, pure primaries, equal channel
    // sums (red against green) and swings large enough to saturate the sum.
    localparam ccdg_pkg::pixel_t EDGE_PIXELS [25] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h808080,
        24'h0000FF, 24'hFFFFFF, 24'h00FF00, 24'h000000, 24'hFFFFFF,
        24'hFF0000, 24'h000000, 24'h00FF00, 24'h0000FF, 24'h0000FF,
        24'h010203, 24'hFEFDFC, 24'h7F7F7F, 24'h808080, 24'hFFFFFF
    };

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    ccdg_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ccdg_pkg::out_item_t             out_data;
    logic                            cfg_we    = 1'b0;
    logic [ccdg_pkg::CFG_IDX_W-1:0]  cfg_index = ccdg_pkg::CFG_RADIUS;
    logic [ccdg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: its own copy of the line store, raster position and
    // register contents, starting from the reset values.
    ccdg_pkg::pixel_t    row_store [ccdg_pkg::DEPTH];
    int unsigned         pix_col    = 0;
    int unsigned         pix_row    = 0;
    logic [2:0]          set_radius = 3'd1;
    logic [10:0]         set_width  = 11'd640;
    logic [10:0]         set_height = 11'd480;
    ccdg_pkg::out_item_t pending_grads [$];

    // Stimulus control
    bit               steady      = 1'b0;  // no idling on either side while set
    int unsigned      hold_req    = 0;     // bumped by a test to ask for a hold-off
    int unsigned      hold_ack    = 0;
    int unsigned      hold_left   = 0;
    ccdg_pkg::pixel_t recent [8];          // last pixels sent, for equal-sum reuse
    int unsigned      sent_count  = 0;
    int unsigned      fault_count = 0;
    int unsigned      cycle_count = 0;

    always #6 clk = ~clk;

    color_central_difference_gradient uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Gradient predictor
    // ---------------------------------------------------------------

    function automatic int unsigned chan_total(ccdg_pkg::pixel_t p);
        return int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16]);
    endfunction

    // Per channel: pixel with the larger channel sum minus the other, floored
    // at zero. On equal sums the first pixel (left or top) counts as larger.
    function automatic ccdg_pkg::pixel_t ordered_diff(ccdg_pkg::pixel_t first,
                                                      ccdg_pkg::pixel_t second);
        ccdg_pkg::pixel_t minuend;
        ccdg_pkg::pixel_t subtrahend;
        ccdg_pkg::pixel_t res;
        int               delta;
        minuend    = first;
        subtrahend = second;
        if (chan_total(second) > chan_total(first))
        begin
            minuend    = second;
            subtrahend = first;
        end
        for (int k = 0; k < 3; k++)
        begin
            delta = int'(minuend[8*k +: 8]) - int'(subtrahend[8*k +: 8]);
            res[8*k +: 8] = (delta > 0) ? 8'(delta) : 8'd0;
        end
        return res;
    endfunction

    function automatic logic [7:0] div_nearest_even(int unsigned s, int unsigned d);
        int unsigned q;
        int unsigned rem;
        q   = s / d;
        rem = s % d;
        if (2 * rem > d || (2 * rem == d && (q % 2) == 1))
            q++;
        return 8'(q);
    endfunction

    // Called once per accepted input transfer, in acceptance order.
    function automatic void predict_gradient(ccdg_pkg::pixel_t cur);
        int unsigned         r;
        int unsigned         w;
        int unsigned         h;
        int unsigned         x;
        int unsigned         y;
        int unsigned         cy;
        int unsigned         s;
        ccdg_pkg::pixel_t    top;
        ccdg_pkg::pixel_t    left;
        ccdg_pkg::pixel_t    right;
        ccdg_pkg::pixel_t    dx;
        ccdg_pkg::pixel_t    dy;
        ccdg_pkg::pixel_t    grad;
        ccdg_pkg::out_item_t res;
        // Register values outside the usable range are pulled back into it
        r = (set_radius == 0) ? 1 :
            ((set_radius > ccdg_pkg::MAX_RAD) ? ccdg_pkg::MAX_RAD : set_radius);
        w = (set_width == 0) ? 1 :
            ((set_width > ccdg_pkg::MAX_DIM) ? ccdg_pkg::MAX_DIM : set_width);
        h = (set_height == 0) ? 1 :
            ((set_height > ccdg_pkg::MAX_DIM) ? ccdg_pkg::MAX_DIM : set_height);
        x = pix_col;
        y = pix_row;
        top = '0;
        if (x < ccdg_pkg::MAX_DIM)
            top = row_store[((y + SLOTS - (2 * r) % SLOTS) % SLOTS) * ccdg_pkg::MAX_DIM + x];
        // Centre sits R rows up; only interior centres give a result
        if (y >= 2 * r && y < h && w > 2 * r && x >= r && x < w - r)
        begin
            cy    = y - r;
            left  = row_store[(cy % SLOTS) * ccdg_pkg::MAX_DIM + x - r];
            right = row_store[(cy % SLOTS) * ccdg_pkg::MAX_DIM + x + r];
            dx    = ordered_diff(left, right);
            dy    = ordered_diff(top, cur);
            for (int k = 0; k < 3; k++)
            begin
                s = int'(dx[8*k +: 8]) + int'(dy[8*k +: 8]);
                if (s > 255)
                    s = 255;
                grad[8*k +: 8] = div_nearest_even(s, r);
            end
            res.grad_blue  = grad[7:0];
            res.grad_green = grad[15:8];
            res.grad_red   = grad[23:16];
            res.frame_last = (y == h - 1) && (x == w - 1 - r);
            pending_grads.push_back(res);
        end
        if (x < ccdg_pkg::MAX_DIM)
            row_store[(y % SLOTS) * ccdg_pkg::MAX_DIM + x] = cur;
        // Raster advance; a counter past a newly lowered limit wraps here
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        pix_col = x;
        pix_row = y;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void note_fault(string what, ccdg_pkg::out_item_t want,
                                       ccdg_pkg::out_item_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s at cycle %0d: expected b=%0d g=%0d r=%0d last=%0b, %s",
                     what, cycle_count, want.grad_blue, want.grad_green, want.grad_red,
                     want.frame_last,
                     $sformatf("got b=%0d g=%0d r=%0d last=%0b", got.grad_blue,
                               got.grad_green, got.grad_red, got.frame_last));
    endfunction

    // Every output transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : check_results
        ccdg_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grads.size() == 0)
                note_fault("unexpected result", '0, out_data);
            else
            begin
                want = pending_grads.pop_front();
                if (out_data.grad_blue !== want.grad_blue
                    || out_data.grad_green !== want.grad_green
                    || out_data.grad_red !== want.grad_red
                    || out_data.frame_last !== want.frame_last)
                    note_fault("result mismatch", want, out_data);
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, none while steady
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_grads.size());
            $display("FAIL color_central_difference_gradient");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // One pixel transfer; valid stays up into the next call unless a gap is
    // drawn, so back-to-back transfers need no re-assertion.
    task automatic send_pixel(ccdg_pkg::pixel_t px);
        in_valid <= 1'b1;
        in_data  <= ccdg_pkg::in_item_t'{blue: px[7:0], green: px[15:8], red: px[23:16]};
        do
            @(posedge clk);
        while (in_stall);
        predict_gradient(px);
        recent[sent_count % 8] = px;
        sent_count++;
        if (!steady && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Mix of uniform pixels, black/white channels and channel rotations of a
    // recent pixel (same channel sum, so the tie rule gets exercised).
    function automatic ccdg_pkg::pixel_t random_pixel();
        ccdg_pkg::pixel_t p;
        int unsigned      pick;
        pick = $urandom_range(99);
        p    = 24'($urandom());
        if (pick < 25)
        begin
            for (int k = 0; k < 3; k++)
                p[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else if (pick < 40 && sent_count != 0)
        begin
            p = recent[$urandom_range(7)];
            p = {p[15:0], p[23:16]};
        end
        return p;
    endfunction

    // Sender pause: wait for every predicted result, then let a pixel that
    // gives no result finish inside the block.
    task automatic settle_stream();
        in_valid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers back to back; only called when idle
    task automatic configure(logic [ccdg_pkg::CFG_DATA_W-1:0] r,
                             logic [ccdg_pkg::CFG_DATA_W-1:0] w,
                             logic [ccdg_pkg::CFG_DATA_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= ccdg_pkg::CFG_RADIUS;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= ccdg_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= ccdg_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we     <= 1'b0;
        set_radius = r[2:0];
        set_width  = w;
        set_height = h;
    endtask

    task automatic send_random(int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-picked extremes on a small frame at radius 1
    task automatic test_edge_frame();
        configure(11'd1, 11'd5, 11'd5);
        foreach (EDGE_PIXELS[i])
            send_pixel(EDGE_PIXELS[i]);
        settle_stream();
    endtask

    // Radius zero behaves as one; smallest frame with an interior, twice
    task automatic test_radius_zero();
        configure(11'd0, 11'd3, 11'd3);
        send_random(18);
        settle_stream();
    endtask

    // Radius above the maximum is held at the maximum
    task automatic test_radius_over();
        configure(11'd7, 11'd9, 11'd9);
        send_random(81);
        settle_stream();
        configure(11'd5, 11'd10, 11'd9);
        send_random(90);
        settle_stream();
    endtask

    // No interior: frame not above 2R, then zero width and height
    task automatic test_no_interior();
        configure(11'd2, 11'd4, 11'd10);
        send_random(40);
        settle_stream();
        configure(11'd1, 11'd0, 11'd0);
        send_random(3);
        settle_stream();
    endtask

    // Zero width counts as one and height beyond 1024 is held at 1024: one
    // pixel per row up to row 1022, then a three-wide tail through the last
    // row, which wraps back to row 0. The tail reads columns 1 and 2 of
    // rows written by the earlier frames. Runs without any idling.
    task automatic test_tall_frame();
        steady = 1'b1;
        configure(11'd1, 11'd0, 11'd2047);
        send_random(ccdg_pkg::MAX_DIM - 2);
        settle_stream();
        configure(11'd1, 11'd3, 11'd2047);
        send_random(6);
        settle_stream();
        steady = 1'b0;
    endtask

    // Largest radius on the widest frame of the random stream. Nine rows
    // write every row slot up to that width, so later tests may reconfigure
    // mid-frame safely.
    task automatic test_fill_frame();
        configure(11'd4, 11'(FILL_WIDTH), 11'd9);
        send_random(FILL_WIDTH * 9);
        settle_stream();
    endtask

    // Receiver holds off long enough for the block to stall its input
    // while the sender keeps offering pixels.
    task automatic test_backpressure();
        configure(11'd2, 11'd12, 11'd12);
        for (int i = 0; i < 144; i++)
        begin
            if (i == 60)
                hold_req++;
            send_pixel(random_pixel());
        end
        settle_stream();
    endtask

    // Random chunks, reconfigured between chunks without regard to frame
    // position. Mostly small frames with an interior; sometimes any radius
    // and height the register fields allow, with zero or narrow widths.
    task automatic test_random_stream();
        int unsigned sent;
        int unsigned r;
        int unsigned chunk;
        logic [ccdg_pkg::CFG_DATA_W-1:0] rad_word;
        logic [ccdg_pkg::CFG_DATA_W-1:0] wid_word;
        logic [ccdg_pkg::CFG_DATA_W-1:0] hgt_word;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(99) < 80)
            begin
                r        = $urandom_range(1, ccdg_pkg::MAX_RAD);
                rad_word = ccdg_pkg::CFG_DATA_W'(r);
                wid_word = ccdg_pkg::CFG_DATA_W'($urandom_range(2 * r + 1, 2 * r + 16));
                hgt_word = ccdg_pkg::CFG_DATA_W'($urandom_range(2 * r + 1, 2 * r + 10));
            end
            else
            begin
                // upper bits of the radius word lie outside the register
                rad_word = ccdg_pkg::CFG_DATA_W'($urandom());
                wid_word = ccdg_pkg::CFG_DATA_W'($urandom_range(0, FILL_WIDTH));
                hgt_word = ccdg_pkg::CFG_DATA_W'($urandom());
            end
            configure(rad_word, wid_word, hgt_word);
            chunk = $urandom_range(20, 200);
            send_random(chunk);
            sent += chunk;
            settle_stream();
        end
    endtask

    initial
    begin
        int unsigned wait_left;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_frame();
        test_radius_zero();
        test_radius_over();
        test_no_interior();
        test_tall_frame();
        test_fill_frame();
        test_backpressure();
        test_random_stream();

        // Bounded wait for stragglers, then anything still owed is a failure
        in_valid <= 1'b0;
        wait_left = 5000;
        while (pending_grads.size() != 0 && wait_left != 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_grads.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_grads.size());
            fault_count += pending_grads.size();
        end

        if (fault_count == 0)
            $display("PASS color_central_difference_gradient");
        else
            $display("FAIL color_central_difference_gradient");
        $finish;
    end

endmodule
